@@ src/assert_macros.svh @@
// Shared assertion macros for the tag table checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("tag table assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	`ASSERT_ALWAYS(lbl, clk, rst_n, (ante) |=> (cons))

`endif

@@ src/bctt_pkg.sv @@
`default_nettype none
package bctt_pkg;
	localparam int unsigned NUM_SLOTS = 512;
	localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
	localparam int unsigned CNT_W     = SLOT_W + 1;
	localparam int unsigned HASH_BITS = 7;
	localparam logic [15:0] REFS_MAX  = 16'hFFFF;

	localparam logic [1:0] CMD_LOOKUP  = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_FILL    = 2'd2;

	localparam logic [2:0] ST_HIT      = 3'd0;
	localparam logic [2:0] ST_MISS     = 3'd1;
	localparam logic [2:0] ST_NO_SPACE = 3'd2;
	localparam logic [2:0] ST_RELEASED = 3'd3;
	localparam logic [2:0] ST_COMMIT   = 3'd4;
	localparam logic [2:0] ST_DROP     = 3'd5;
	localparam logic [2:0] ST_BUSY     = 3'd6;
	localparam logic [2:0] ST_BAD      = 3'd7;

	typedef struct packed {
		logic        valid;
		logic [15:0] refs;
		logic [31:0] age;
		logic [31:0] device;
		logic [63:0] blk;
	} entry_t;
endpackage
`default_nettype wire

@@ src/bctt_req_if.sv @@
`default_nettype none
interface bctt_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    cmd;
	logic [31:0]                   device;
	logic [63:0]                   block_number;
	logic [bctt_pkg::SLOT_W-1:0]   slot_in;
	logic                          fill_ok;

	modport source (output valid, cmd, device, block_number, slot_in, fill_ok, input ready);
	modport sink (input valid, cmd, device, block_number, slot_in, fill_ok, output ready);
endinterface
`default_nettype wire

@@ src/bctt_rsp_if.sv @@
`default_nettype none
interface bctt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    status;
	logic [bctt_pkg::SLOT_W-1:0]   slot_out;
	logic                          evicted;
	logic [15:0]                   ref_count;

	modport source (output valid, status, slot_out, evicted, ref_count, input ready);
	modport sink (input valid, status, slot_out, evicted, ref_count, output ready);
endinterface
`default_nettype wire

@@ src/buffer_cache_tag_table.sv @@
// Tag and refcount store of a block buffer cache, 512 slots.
// Channel req (valid/ready) carries one command item: lookup, release or
// fill result. Channel rsp (valid/ready) returns exactly one result item
// per command, in order.
// One command is worked on at a time; req.ready is high only when idle.
// Lookup: the whole entry memory is read one slot per cycle to find a hit,
// the lowest free slot and the eviction victim; then S_DECIDE writes the
// entry and registers the result, and S_FIN loads it into the output
// register. A lookup while a fill is pending answers busy without a scan.
// Release and fill result: one read-modify-write of the entry memory, read
// in S_FETCH and written in S_MOD. A fill result with no fill pending, a
// release of an invalid slot or an unknown command answers bad request.
// The entry memory has one read port and one write port.
// After reset the block clears the entry memory, one slot per cycle, and
// holds req.ready low meanwhile.
// The result sits in an output register; when rsp.ready is low it holds,
// the block may still accept and work the next item, and waits before
// loading the next result until the register is taken.
`default_nettype none
module buffer_cache_tag_table (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bctt_req_if.sink   req,
	bctt_rsp_if.source rsp
);
	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_FETCH, S_MOD, S_FIN
	} state_t;

	localparam int unsigned SW = bctt_pkg::SLOT_W;
	localparam int unsigned CW = bctt_pkg::CNT_W;
	localparam int unsigned HB = bctt_pkg::HASH_BITS;

	bctt_pkg::entry_t mem [bctt_pkg::NUM_SLOTS];
	bctt_pkg::entry_t rd_q;
	bctt_pkg::entry_t wdata;
	logic             wen, ren;
	logic [SW-1:0]    waddr, raddr;

	state_t        state_q;
	logic [SW-1:0] clr_q;
	logic [CW-1:0] scan_q;
	logic          rd_v_s1;
	logic [SW-1:0] idx_s1;

	logic [1:0]    cmd_q;
	logic [31:0]   dev_q;
	logic [63:0]   blk_q;
	logic [SW-1:0] slot_q;
	logic          ok_q;

	logic [31:0]   ic_q;
	logic [CW-1:0] used_q;
	logic          pend_q;
	logic [SW-1:0] pend_slot_q;

	logic          hit_q, free_found_q, vic_found_q;
	logic [SW-1:0] hit_slot_q, free_slot_q, vic_slot_q;
	logic [15:0]   hit_refs_q;
	logic [31:0]   hit_age_q, vic_dist_q;
	logic [HB-1:0] vic_bkt_q;

	logic [2:0]    res_status_q;
	logic [SW-1:0] res_slot_q;
	logic          res_ev_q;
	logic [15:0]   res_refs_q;

	logic          out_valid_q;
	logic [2:0]    out_status_q;
	logic [SW-1:0] out_slot_q;
	logic          out_ev_q;
	logic [15:0]   out_refs_q;
	logic          load_out;

	// decision outputs of S_DECIDE and S_MOD
	logic [2:0]    nxt_status;
	logic [SW-1:0] nxt_slot;
	logic          nxt_ev;
	logic [15:0]   nxt_refs;
	logic          alloc;
	logic [SW-1:0] alloc_slot;
	logic [15:0]   hit_refs_new, rel_refs_new;

	logic [HB-1:0] scan_bkt;
	logic [31:0]   scan_dist;
	logic          scan_hit, scan_vic_ok, scan_better;

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.slot_out  = out_slot_q;
	assign rsp.evicted   = out_ev_q;
	assign rsp.ref_count = out_refs_q;

	assign load_out = (state_q == S_FIN) && (!out_valid_q || rsp.ready);

	assign hit_refs_new = (hit_refs_q == bctt_pkg::REFS_MAX) ? hit_refs_q : hit_refs_q + 16'd1;
	assign rel_refs_new = (rd_q.refs == 16'd0) ? 16'd0 : rd_q.refs - 16'd1;

	assign scan_bkt    = rd_q.device[HB-1:0] ^ rd_q.blk[HB-1:0];
	assign scan_dist   = ic_q - rd_q.age;
	assign scan_hit    = rd_q.valid && (rd_q.device == dev_q) && (rd_q.blk == blk_q);
	assign scan_vic_ok = rd_q.valid && (rd_q.refs == 16'd0);
	assign scan_better = !vic_found_q || (scan_bkt < vic_bkt_q) ||
		((scan_bkt == vic_bkt_q) && (scan_dist < vic_dist_q));

	always_comb begin
		ren        = 1'b0;
		raddr      = scan_q[SW-1:0];
		wen        = 1'b0;
		waddr      = clr_q;
		wdata      = '0;
		nxt_status = bctt_pkg::ST_BAD;
		nxt_slot   = '0;
		nxt_ev     = 1'b0;
		nxt_refs   = 16'd0;
		alloc      = 1'b0;
		alloc_slot = free_slot_q;
		case (state_q)
			S_CLEAR: begin
				wen = 1'b1;
			end
			S_SCAN: begin
				ren = (scan_q < CW'(bctt_pkg::NUM_SLOTS));
			end
			S_FETCH: begin
				ren   = 1'b1;
				raddr = (cmd_q == bctt_pkg::CMD_RELEASE) ? slot_q : pend_slot_q;
			end
			S_DECIDE: begin
				if (hit_q) begin
					wen        = 1'b1;
					waddr      = hit_slot_q;
					wdata      = '{valid: 1'b1, refs: hit_refs_new, age: hit_age_q,
						device: dev_q, blk: blk_q};
					nxt_status = bctt_pkg::ST_HIT;
					nxt_slot   = hit_slot_q;
					nxt_refs   = hit_refs_new;
				end else if (used_q < CW'(bctt_pkg::NUM_SLOTS)) begin
					alloc = 1'b1;
				end else if (vic_found_q) begin
					alloc      = 1'b1;
					alloc_slot = vic_slot_q;
					nxt_ev     = 1'b1;
				end else begin
					nxt_status = bctt_pkg::ST_NO_SPACE;
				end
				if (alloc) begin
					wen        = 1'b1;
					waddr      = alloc_slot;
					wdata      = '{valid: 1'b0, refs: 16'd1, age: 32'd0,
						device: dev_q, blk: blk_q};
					nxt_status = bctt_pkg::ST_MISS;
					nxt_slot   = alloc_slot;
					nxt_refs   = 16'd1;
				end
			end
			S_MOD: begin
				if (cmd_q == bctt_pkg::CMD_RELEASE) begin
					if (rd_q.valid) begin
						wen        = 1'b1;
						waddr      = slot_q;
						wdata      = rd_q;
						wdata.refs = rel_refs_new;
						nxt_status = bctt_pkg::ST_RELEASED;
						nxt_slot   = slot_q;
						nxt_refs   = rel_refs_new;
					end
				end else begin
					wen      = 1'b1;
					waddr    = pend_slot_q;
					wdata    = rd_q;
					nxt_slot = pend_slot_q;
					if (ok_q) begin
						wdata.valid = 1'b1;
						wdata.age   = ic_q;
						nxt_status  = bctt_pkg::ST_COMMIT;
						nxt_refs    = rd_q.refs;
					end else begin
						wdata.refs = 16'd0;
						nxt_status = bctt_pkg::ST_DROP;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			scan_q       <= '0;
			rd_v_s1      <= 1'b0;
			idx_s1       <= '0;
			cmd_q        <= '0;
			dev_q        <= '0;
			blk_q        <= '0;
			slot_q       <= '0;
			ok_q         <= 1'b0;
			ic_q         <= '0;
			used_q       <= '0;
			pend_q       <= 1'b0;
			pend_slot_q  <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
			hit_slot_q   <= '0;
			free_slot_q  <= '0;
			vic_slot_q   <= '0;
			hit_refs_q   <= '0;
			hit_age_q    <= '0;
			vic_dist_q   <= '0;
			vic_bkt_q    <= '0;
			res_status_q <= '0;
			res_slot_q   <= '0;
			res_ev_q     <= 1'b0;
			res_refs_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_slot_q   <= '0;
			out_ev_q     <= 1'b0;
			out_refs_q   <= '0;
		end else begin
			rd_v_s1 <= (state_q == S_SCAN) && ren;
			idx_s1  <= raddr;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SW'(bctt_pkg::NUM_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						cmd_q        <= req.cmd;
						dev_q        <= req.device;
						blk_q        <= req.block_number;
						slot_q       <= req.slot_in;
						ok_q         <= req.fill_ok;
						res_status_q <= (req.cmd == bctt_pkg::CMD_LOOKUP && pend_q) ?
							bctt_pkg::ST_BUSY : bctt_pkg::ST_BAD;
						res_slot_q   <= '0;
						res_ev_q     <= 1'b0;
						res_refs_q   <= '0;
						if (req.cmd == bctt_pkg::CMD_LOOKUP && !pend_q) begin
							hit_q        <= 1'b0;
							free_found_q <= 1'b0;
							vic_found_q  <= 1'b0;
							scan_q       <= '0;
							state_q      <= S_SCAN;
						end else if (req.cmd == bctt_pkg::CMD_RELEASE) begin
							state_q <= S_FETCH;
						end else if (req.cmd == bctt_pkg::CMD_FILL && pend_q) begin
							state_q <= S_FETCH;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					if (ren) begin
						scan_q <= scan_q + 1'b1;
					end
					if (rd_v_s1) begin
						if (scan_hit && !hit_q) begin
							hit_q      <= 1'b1;
							hit_slot_q <= idx_s1;
							hit_refs_q <= rd_q.refs;
							hit_age_q  <= rd_q.age;
						end
						if (!rd_q.valid && !free_found_q) begin
							free_found_q <= 1'b1;
							free_slot_q  <= idx_s1;
						end
						if (scan_vic_ok && scan_better) begin
							vic_found_q <= 1'b1;
							vic_slot_q  <= idx_s1;
							vic_bkt_q   <= scan_bkt;
							vic_dist_q  <= scan_dist;
						end
						if (idx_s1 == SW'(bctt_pkg::NUM_SLOTS - 1)) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					if (alloc) begin
						pend_q      <= 1'b1;
						pend_slot_q <= alloc_slot;
						if (!nxt_ev) begin
							used_q <= used_q + 1'b1;
						end
					end
					res_status_q <= nxt_status;
					res_slot_q   <= nxt_slot;
					res_ev_q     <= nxt_ev;
					res_refs_q   <= nxt_refs;
					state_q      <= S_FIN;
				end
				S_FETCH: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (cmd_q != bctt_pkg::CMD_RELEASE) begin
						pend_q <= 1'b0;
						if (ok_q) begin
							ic_q <= ic_q + 32'd1;
						end else if (used_q != '0) begin
							used_q <= used_q - 1'b1;
						end
					end
					res_status_q <= nxt_status;
					res_slot_q   <= nxt_slot;
					res_ev_q     <= nxt_ev;
					res_refs_q   <= nxt_refs;
					state_q      <= S_FIN;
				end
				S_FIN: begin
					// wait until the output register is free
					if (load_out) begin
						out_status_q <= res_status_q;
						out_slot_q   <= res_slot_q;
						out_ev_q     <= res_ev_q;
						out_refs_q   <= res_refs_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

@@ src/bctt_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module bctt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [2:0]  rsp_status,
	input wire logic        rsp_evicted,
	input wire logic [15:0] rsp_ref_count
);
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready)
	`ASSERT_ALWAYS(a_evict_on_miss, clk, arst_n, (rsp_valid && rsp_evicted) |-> (rsp_status == bctt_pkg::ST_MISS))
	`ASSERT_ALWAYS(a_hit_refs, clk, arst_n, (rsp_valid && (rsp_status == bctt_pkg::ST_HIT || rsp_status == bctt_pkg::ST_MISS)) |-> (rsp_ref_count != 16'd0))
endmodule

bind buffer_cache_tag_table bctt_checker u_bctt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_evicted  (rsp.evicted),
	.rsp_ref_count(rsp.ref_count)
);
`default_nettype wire
